// ----- hdl/minhash_signature_engine_macros.svh -----
// ----------------------------------------------------------------------------
// MinHash signature engine - assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MINHASH_SIGNATURE_ENGINE_MACROS_SVH
`define MINHASH_SIGNATURE_ENGINE_MACROS_SVH

// Check sampled on the rising clock, masked while reset is asserted.
`define MHSE_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check sampled on the rising clock, live during reset as well.
`define MHSE_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mhse_pkg.sv -----
// ----------------------------------------------------------------------------
// mhse_pkg
// Shared sizes, codes and transaction types of the MinHash signature engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mhse_pkg;

    // Number of hash lanes (one cell each), 1..64.
    localparam int NUM_HASHES = 8;

    // A readout reports at most eight lanes.
    localparam int MAX_OUT    = 8;
    localparam int NUM_OUT    = (NUM_HASHES < MAX_OUT) ? NUM_HASHES : MAX_OUT;

    localparam int CELL_W     = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int IDX_W      = (CELL_W > 3) ? CELL_W : 3;
    localparam int OUT_CNT_W  = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;

    localparam logic [2:0] LAST_LANE = 3'(NUM_OUT - 1);

    // Action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_SHINGLE = 2'd1;
    localparam logic [1:0] ACT_READOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  lane;
        logic [63:0] coef_a;
        logic [63:0] coef_b;
        logic [31:0] init_min;
        logic [63:0] base_hash;
    } mhse_in_t;

    typedef struct packed {
        logic [2:0]  out_lane;
        logic [31:0] signature;
        logic        last;
    } mhse_out_t;

    // Transaction as it travels down the cell chain.
    typedef struct packed {
        logic     valid;
        mhse_in_t data;
    } mhse_item_t;

    // Readout wave: collects one minimum per reported lane.
    typedef struct packed {
        logic                      valid;
        logic [NUM_OUT-1:0][31:0]  sig;
    } mhse_res_t;

endpackage

`default_nettype wire

// ----- hdl/mhse_cell.sv -----
// ----------------------------------------------------------------------------
// mhse_cell
// One hash lane: coefficients, 64-bit linear hash, 2^61-1 fold, running min.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mhse_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       adv,
    input  wire logic [mhse_pkg::CELL_W-1:0] cell_idx,
    input  wire mhse_pkg::mhse_item_t       item_i,
    output mhse_pkg::mhse_item_t            item_o,
    input  wire mhse_pkg::mhse_res_t        res_i,
    output mhse_pkg::mhse_res_t             res_o
);

    localparam int NUM_OUT_SLOTS = mhse_pkg::NUM_OUT;

    typedef enum logic [1:0] {
        KIND_IDLE,
        KIND_LOAD,
        KIND_SHINGLE,
        KIND_READOUT
    } kind_t;

    // lane state
    logic [63:0] a_reg, b_reg;
    logic [31:0] min_reg;

    // stage 1: partial products
    kind_t       s1_kind_reg;
    logic [63:0] s1_p0_reg;
    logic [31:0] s1_p1_reg, s1_p2_reg;
    logic [63:0] s1_b_reg;
    logic [31:0] s1_init_reg;

    // stage 2: wrapped a*x+b
    kind_t       s2_kind_reg;
    logic [63:0] s2_t_reg;
    logic [31:0] s2_init_reg;

    mhse_pkg::mhse_item_t item_reg;
    mhse_pkg::mhse_res_t  res_reg;

    kind_t       in_kind;
    logic        lane_hit;
    logic [63:0] p0_next;
    logic [31:0] p1_next, p2_next;
    logic [63:0] t_next;
    logic [61:0] fold_sum;
    logic        fold_wrap;
    logic [31:0] hash_val;
    logic [NUM_OUT_SLOTS-1:0][31:0] sig_next;

    always_comb begin
        lane_hit = (mhse_pkg::IDX_W'(item_i.data.lane) == mhse_pkg::IDX_W'(cell_idx));
        in_kind  = KIND_IDLE;
        if (item_i.valid) begin
            case (item_i.data.action)
                mhse_pkg::ACT_LOAD:    in_kind = lane_hit ? KIND_LOAD : KIND_IDLE;
                mhse_pkg::ACT_SHINGLE: in_kind = KIND_SHINGLE;
                mhse_pkg::ACT_READOUT: in_kind = KIND_READOUT;
                default:               in_kind = KIND_IDLE;
            endcase
        end
    end

    // low 64 bits of a*x from three 32x32 products
    assign p0_next = {32'd0, a_reg[31:0]} * {32'd0, item_i.data.base_hash[31:0]};
    assign p1_next = a_reg[31:0]  * item_i.data.base_hash[63:32];
    assign p2_next = a_reg[63:32] * item_i.data.base_hash[31:0];

    assign t_next = s1_p0_reg + {s1_p1_reg + s1_p2_reg, 32'd0} + s1_b_reg;

    // fold: s = lo61 + hi3; s >= P subtracts P, low 32 bits of -P are +1
    assign fold_sum  = {1'b0, s2_t_reg[60:0]} + {59'd0, s2_t_reg[63:61]};
    assign fold_wrap = fold_sum[61] | (&fold_sum[60:0]);
    assign hash_val  = fold_wrap ? (fold_sum[31:0] + 32'd1) : fold_sum[31:0];

    always_comb begin
        sig_next = res_i.sig;
        if (s2_kind_reg == KIND_READOUT) begin
            for (int k = 0; k < NUM_OUT_SLOTS; k++) begin
                if (mhse_pkg::IDX_W'(cell_idx) == mhse_pkg::IDX_W'(k)) begin
                    sig_next[k] = min_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg          <= '0;
            b_reg          <= '0;
            min_reg        <= '1;
            s1_kind_reg    <= KIND_IDLE;
            s2_kind_reg    <= KIND_IDLE;
            item_reg.valid <= 1'b0;
            res_reg.valid  <= 1'b0;
        end else if (adv) begin
            if (in_kind == KIND_LOAD) begin
                a_reg <= item_i.data.coef_a;
                b_reg <= item_i.data.coef_b;
            end
            s1_kind_reg <= in_kind;
            s1_p0_reg   <= p0_next;
            s1_p1_reg   <= p1_next;
            s1_p2_reg   <= p2_next;
            s1_b_reg    <= b_reg;
            s1_init_reg <= item_i.data.init_min;

            s2_kind_reg <= s1_kind_reg;
            s2_t_reg    <= t_next;
            s2_init_reg <= s1_init_reg;

            if (s2_kind_reg == KIND_LOAD) begin
                min_reg <= s2_init_reg;
            end else if ((s2_kind_reg == KIND_SHINGLE) && (hash_val < min_reg)) begin
                min_reg <= hash_val;
            end

            item_reg      <= item_i;
            res_reg.valid <= (s2_kind_reg == KIND_READOUT);
            res_reg.sig   <= sig_next;
        end
    end

    assign item_o = item_reg;
    assign res_o  = res_reg;

endmodule

`default_nettype wire

// ----- hdl/mhse_ser.sv -----
// ----------------------------------------------------------------------------
// mhse_ser
// Output stage: turns one collected readout into per-lane result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mhse_ser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mhse_pkg::mhse_res_t tail_i,
    output logic                     room_o,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mhse_pkg::mhse_out_t      m_data
);

    logic                                  busy_reg;
    logic [mhse_pkg::OUT_CNT_W-1:0]        idx_reg;
    logic [mhse_pkg::NUM_OUT-1:0][31:0]    vec_reg;
    logic                                  at_last;

    assign at_last = (idx_reg == mhse_pkg::OUT_CNT_W'(mhse_pkg::NUM_OUT - 1));
    // free now, or freeing at this edge
    assign room_o  = !busy_reg || (m_ready && at_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (tail_i.valid && room_o) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            vec_reg  <= tail_i.sig;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 1'b1;
            for (int k = 0; k < mhse_pkg::NUM_OUT - 1; k++) begin
                vec_reg[k] <= vec_reg[k+1];
            end
        end
    end

    assign m_valid          = busy_reg;
    assign m_data.out_lane  = 3'(idx_reg);
    assign m_data.signature = vec_reg[0];
    assign m_data.last      = at_last;

endmodule

`default_nettype wire

// ----- hdl/minhash_signature_engine.sv -----
// ----------------------------------------------------------------------------
// minhash_signature_engine
// MinHash signature engine: a chain of hash-lane cells with 2^61-1 folding.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel (valid/ready) carries one transaction per item: a lane load
//   (coefficients a, b and a starting minimum), a shingle (64-bit base hash)
//   or a readout request. m_* channel (valid/ready) returns, for a readout,
//   one transaction per reported lane (lanes 0 .. min(NUM_HASHES,8)-1), with
//   last set on the final one. Loads and shingles return nothing.
// Throughput: one input transaction per clock while s_ready is high. Each
//   cell does a three-part multiply, a 64-bit sum and the fold/min in three
//   stages, and hands the transaction to its neighbor every clock unless held.
// Readout path: input register, each cell's item register, the last cell's
//   stages, output stage; lanes then leave one per cycle while m_ready is high.
// Output stalls: the chain keeps flowing until a readout reaches its end while
//   the output stage still holds the previous readout; then the whole chain
//   (and s_ready) holds until that readout drains through the single output
//   port, one lane at a time.
// Reset: aresetn (synchronous, active low) zeroes all coefficients, sets every
//   minimum to all ones and empties the pipeline; no results are pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module minhash_signature_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mhse_pkg::mhse_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mhse_pkg::mhse_out_t       m_data
);

    // item_chain[i] feeds cell i; res_chain[i] is the readout wave into cell i
    mhse_pkg::mhse_item_t item_chain [mhse_pkg::NUM_HASHES+1];
    mhse_pkg::mhse_res_t  res_chain  [mhse_pkg::NUM_HASHES+1];

    mhse_pkg::mhse_item_t in_reg;
    logic                 adv;
    logic                 room;

    // Global advance: everything moves unless a finished readout is stuck
    // at the chain tail.
    assign adv     = !res_chain[mhse_pkg::NUM_HASHES].valid || room;
    assign s_ready = adv;

    // Input register keeps the port off the first cell's multipliers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (adv) begin
            in_reg.valid <= s_valid;
            in_reg.data  <= s_data;
        end
    end

    assign item_chain[0] = in_reg;
    assign res_chain[0]  = '0;

    for (genvar g = 0; g < mhse_pkg::NUM_HASHES; g++) begin : g_cell
        mhse_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .cell_idx (mhse_pkg::CELL_W'(g)),
            .item_i   (item_chain[g]),
            .item_o   (item_chain[g+1]),
            .res_i    (res_chain[g]),
            .res_o    (res_chain[g+1])
        );
    end

    // Tail readout -> per-lane result transactions
    mhse_ser u_ser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tail_i  (res_chain[mhse_pkg::NUM_HASHES]),
        .room_o  (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- hdl/mhse_checker.sv -----
// ----------------------------------------------------------------------------
// mhse_checker
// Port-level checks of the MinHash signature engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "minhash_signature_engine_macros.svh"

module mhse_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire mhse_pkg::mhse_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire mhse_pkg::mhse_out_t m_data
);

    `MHSE_ASSERT(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `MHSE_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    `MHSE_ASSERT_RST(a_lane_step, aclk, aresetn, m_valid && m_ready && !m_data.last |=> m_valid && (m_data.out_lane == $past(m_data.out_lane) + 3'd1), "readout lanes not consecutive")

    `MHSE_ASSERT_RST(a_last_lane, aclk, aresetn, m_valid |-> (m_data.last == (m_data.out_lane == mhse_pkg::LAST_LANE)), "last flag misplaced")

    `MHSE_ASSERT_RST(a_lane_range, aclk, aresetn, m_valid |-> (m_data.out_lane <= mhse_pkg::LAST_LANE), "reported lane out of range")

endmodule

bind minhash_signature_engine mhse_checker u_mhse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
